// ----- sv/mpbm_pkg.sv -----
package mpbm_pkg;

  localparam int NUM_PATTERNS = 4;
  localparam int MAX_LEN      = 8;

  localparam int NUM_PATTERN_REGS = 4;
  localparam int PAT_W            = 64;
  localparam int LEN_W            = 4;
  localparam int LENGTHS_W        = 16;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_INDEX_W      = 3;
  localparam int POS_W            = 32;
  localparam int TOTAL_W          = 32;
  localparam int IDX_W            = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int HITS_W           = $clog2(NUM_PATTERNS + 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_ZERO  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_ONE   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_TWO   = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_THREE = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTHS       = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] CFG_CASE          = CFG_INDEX_W'(5);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] length;
  } lane_cfg_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

// ----- sv/multi_pattern_byte_matcher.sv -----
// result path: input register, then result register
// throughput: one item per cycle unless a result waits on out_ready; every pattern lane compares in parallel
// the input stalls only while the input register is full and a result waits on out_ready
// reset (rst, synchronous, active high) clears pattern progress, byte position,
// match total, both valid flags and all configuration registers to zero
module multi_pattern_byte_matcher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mpbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mpbm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          data_byte,
  input  logic                                first_of_buffer,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mpbm_pkg::NUM_PATTERNS-1:0]   match_mask,
  output logic [mpbm_pkg::POS_W-1:0]          byte_position,
  output logic [mpbm_pkg::TOTAL_W-1:0]        total_matches
);
  import mpbm_pkg::*;

  logic [PAT_W-1:0]     pattern_regs [NUM_PATTERN_REGS];
  logic [LENGTHS_W-1:0] pattern_lengths;
  logic                 case_sens;

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_first;
  logic                 advance;

  logic [POS_W-1:0]     position_count;
  logic [POS_W-1:0]     pos;
  logic [TOTAL_W-1:0]   match_total;
  logic [TOTAL_W-1:0]   match_total_next;
  logic [TOTAL_W:0]     total_sum;
  logic [HITS_W-1:0]    hit_count;
  logic [NUM_PATTERNS-1:0] hits;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PATTERN_REGS; k++) begin
        pattern_regs[k] <= '0;
      end
      pattern_lengths <= '0;
      case_sens       <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PATTERN_ZERO:  pattern_regs[0] <= cfg_data;
        CFG_PATTERN_ONE:   pattern_regs[1] <= cfg_data;
        CFG_PATTERN_TWO:   pattern_regs[2] <= cfg_data;
        CFG_PATTERN_THREE: pattern_regs[3] <= cfg_data;
        CFG_LENGTHS:       pattern_lengths <= cfg_data[LENGTHS_W-1:0];
        CFG_CASE:          case_sens       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_first <= first_of_buffer;
    end
  end

  for (genvar k = 0; k < NUM_PATTERNS; k++) begin : g_lane
    lane_cfg_t lane_cfg;

    always_comb begin
      if (k < NUM_PATTERN_REGS) begin
        lane_cfg.pattern = pattern_regs[k % NUM_PATTERN_REGS];
        lane_cfg.length  = pattern_lengths[(k % NUM_PATTERN_REGS) * LEN_W +: LEN_W];
      end else begin
        lane_cfg.pattern = '0;
        lane_cfg.length  = '0;
      end
    end

    mpbm_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .advance        (advance),
      .cfg            (lane_cfg),
      .case_sensitive (case_sens),
      .data_byte      (s1_byte),
      .hit            (hits[k])
    );
  end

  always_comb begin
    hit_count = '0;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      hit_count = hit_count + HITS_W'(hits[k]);
    end
    total_sum = {1'b0, match_total} + (TOTAL_W + 1)'(hit_count);
    match_total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    pos = s1_first ? '0 : position_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      match_total    <= '0;
    end else if (advance) begin
      position_count <= pos + POS_W'(1);
      match_total    <= match_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      match_mask    <= hits;
      byte_position <= pos;
      total_matches <= match_total_next;
    end
  end

endmodule

// ----- sv/mpbm_lane.sv -----
module mpbm_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  mpbm_pkg::lane_cfg_t cfg,
  input  logic               case_sensitive,
  input  logic [7:0]         data_byte,
  output logic               hit
);
  import mpbm_pkg::*;

  logic [LEN_W-1:0] progress;
  logic [LEN_W-1:0] progress_next;
  logic [LEN_W-1:0] p_eff;
  logic [LEN_W-1:0] p_inc;
  logic             len_ok;
  logic [7:0]       pat_byte;
  logic             equal;

  always_comb begin
    len_ok = (cfg.length != '0) && (cfg.length <= LEN_W'(MAX_LEN));
    p_eff  = (progress >= cfg.length) ? '0 : progress;
    pat_byte = cfg.pattern[{p_eff[IDX_W-1:0], 3'b000} +: 8];
    if (case_sensitive) begin
      equal = (pat_byte == data_byte);
    end else begin
      equal = (fold_byte(pat_byte) == fold_byte(data_byte));
    end
    p_inc = p_eff + LEN_W'(1);
    hit   = 1'b0;
    progress_next = '0;
    if (len_ok && equal) begin
      if (p_inc == cfg.length) begin
        hit = 1'b1;
      end else begin
        progress_next = p_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      progress <= '0;
    end else if (advance) begin
      progress <= progress_next;
    end
  end

endmodule

// ----- sv/mpbm_checker.sv -----
module mpbm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mpbm_pkg::NUM_PATTERNS-1:0] match_mask,
  input logic [mpbm_pkg::POS_W-1:0]        byte_position,
  input logic [mpbm_pkg::TOTAL_W-1:0]      total_matches
);
  import mpbm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_mask) &&
      $stable(byte_position) && $stable(total_matches))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // input side only stalls behind a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // a match implies a nonzero total
  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (match_mask != '0) |-> total_matches != '0)
    else $error("match reported with zero total");

endmodule

bind multi_pattern_byte_matcher mpbm_checker u_mpbm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .match_mask    (match_mask),
  .byte_position (byte_position),
  .total_matches (total_matches)
);

// ----- verif/tb_multi_pattern_byte_matcher.sv -----
module tb_multi_pattern_byte_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import mpbm_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = CFG_INDEX_W'(6);
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = CFG_INDEX_W'(7);
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 65;

  typedef struct packed {
    logic [NUM_PATTERNS-1:0] mask;
    logic [POS_W-1:0]        position;
    logic [TOTAL_W-1:0]      total;
  } match_t;

  class match_scoreboard;
    logic [PAT_W-1:0]     pattern_bytes [NUM_PATTERN_REGS];
    logic [LENGTHS_W-1:0] length_nibbles;
    logic                 exact_compare;
    logic [LEN_W-1:0]     progress [NUM_PATTERNS];
    logic [POS_W-1:0]     next_position;
    logic [TOTAL_W-1:0]   match_count;
    match_t               expected_matches [$];
    int                   errors;

    function new();
      foreach (pattern_bytes[k]) pattern_bytes[k] = '0;
      foreach (progress[k]) progress[k] = '0;
      length_nibbles = '0;
      exact_compare  = 1'b0;
      next_position  = '0;
      match_count    = '0;
      errors         = 0;
    endfunction

    task report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return expected_matches.size();
    endfunction

    function void set_register(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
      if (idx <= CFG_PATTERN_THREE) begin
        pattern_bytes[idx - CFG_PATTERN_ZERO] = value[PAT_W-1:0];
      end else if (idx == CFG_LENGTHS) begin
        length_nibbles = value[LENGTHS_W-1:0];
      end else if (idx == CFG_CASE) begin
        exact_compare = value[0];
      end
    endfunction

    function logic [7:0] lower(input logic [7:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    function logic same_byte(input logic [7:0] a, input logic [7:0] b);
      if (exact_compare) return a == b;
      return lower(a) == lower(b);
    endfunction

    function void note_byte(input logic [7:0] c, input logic first);
      match_t           want;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] p;
      logic [7:0]       pb;
      int               k;
      if (first) next_position = '0;
      want.position = next_position;
      next_position = next_position + 1'b1;
      want.mask = '0;
      for (k = 0; k < NUM_PATTERNS; k++) begin
        len = (k < NUM_PATTERN_REGS) ? length_nibbles[LEN_W*k +: LEN_W] : '0;
        if (len > MAX_LEN) len = '0;
        if (len == '0) begin
          progress[k] = '0;
        end else begin
          p = (progress[k] >= len) ? '0 : progress[k];
          pb = pattern_bytes[k][8*p[2:0] +: 8];
          if (same_byte(pb, c)) begin
            p = p + 1'b1;
            if (p == len) begin
              want.mask[k] = 1'b1;
              if (match_count != '1) match_count = match_count + 1'b1;
              p = '0;
            end
            progress[k] = p;
          end else begin
            progress[k] = '0;
          end
        end
      end
      want.total = match_count;
      expected_matches.push_back(want);
    endfunction

    task check_result(input logic [NUM_PATTERNS-1:0] mask,
                      input logic [POS_W-1:0] pos,
                      input logic [TOTAL_W-1:0] total);
      match_t want;
      if (expected_matches.size() == 0) begin
        report($sformatf("result with no item waiting: mask %h pos %0d total %0d",
                         mask, pos, total));
      end else begin
        want = expected_matches.pop_front();
        if (mask !== want.mask)
          report($sformatf("match_mask %h, expected %h", mask, want.mask));
        if (pos !== want.position)
          report($sformatf("byte_position %0d, expected %0d", pos, want.position));
        if (total !== want.total)
          report($sformatf("total_matches %0d, expected %0d", total, want.total));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] data_byte;
  logic first_of_buffer;
  logic out_valid;
  logic out_ready;
  logic [NUM_PATTERNS-1:0] match_mask;
  logic [POS_W-1:0] byte_position;
  logic [TOTAL_W-1:0] total_matches;

  match_scoreboard scoreboard;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_request;
  int cycle_count;
  int lane_len [NUM_PATTERNS];
  logic [PAT_W-1:0] lane_pat [NUM_PATTERNS];
  logic [7:0] alphabet [4];

  multi_pattern_byte_matcher DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .first_of_buffer (first_of_buffer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .match_mask      (match_mask),
    .byte_position   (byte_position),
    .total_matches   (total_matches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] vary_case(input logic [7:0] b);
    logic [7:0] low;
    low = b | CASE_OFFSET;
    if (low >= (CHAR_UPPER_A | CASE_OFFSET) && low <= (CHAR_UPPER_Z | CASE_OFFSET) &&
        $urandom_range(1) == 1)
      return b ^ CASE_OFFSET;
    return b;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    scoreboard.set_register(idx, value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    data_byte       <= b;
    first_of_buffer <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scoreboard.note_byte(b, first);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_setup(input int phase);
    logic [LENGTHS_W-1:0] lens;
    logic [PAT_W-1:0] pat;
    logic [CFG_DATA_W-1:0] word;
    int k;
    int j;
    for (j = 0; j < 4; j++) begin
      case ($urandom_range(3))
        0: alphabet[j] = CHAR_UPPER_A + CASE_OFFSET + 8'($urandom_range(2));
        1: alphabet[j] = CHAR_UPPER_A + 8'($urandom_range(2));
        2: alphabet[j] = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
        default: alphabet[j] = 8'($urandom_range(255));
      endcase
    end
    lens = '0;
    for (k = 0; k < NUM_PATTERNS; k++) begin
      case (phase)
        0: lane_len[k] = MAX_LEN;
        1: lane_len[k] = 1;
        2: lane_len[k] = 15;
        default: begin
          if ($urandom_range(9) == 0)
            lane_len[k] = ($urandom_range(1) == 1) ? 0 : $urandom_range(15, MAX_LEN + 1);
          else
            lane_len[k] = $urandom_range(MAX_LEN, 1);
        end
      endcase
      lens[LEN_W*k +: LEN_W] = LEN_W'(lane_len[k]);
      for (j = 0; j < 8; j++)
        pat[8*j +: 8] = (j < lane_len[k]) ? alphabet[$urandom_range(3)]
                                          : 8'($urandom_range(255));
      lane_pat[k] = pat;
      write_reg(CFG_INDEX_W'(CFG_PATTERN_ZERO + k), pat);
    end
    word = {$urandom, $urandom};
    word[LENGTHS_W-1:0] = lens;
    write_reg(CFG_LENGTHS, word);
    word = {$urandom, $urandom};
    word[0] = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(1));
    write_reg(CFG_CASE, word);
    if (phase % 3 == 2) begin
      write_reg(CFG_UNUSED_LO, {$urandom, $urandom});
      write_reg(CFG_UNUSED_HI, {$urandom, $urandom});
    end
  endtask

  task automatic random_text(input int count);
    int sent;
    int k;
    int j;
    logic [7:0] b;
    sent = 0;
    while (sent < count) begin
      k = $urandom_range(NUM_PATTERNS - 1);
      if ($urandom_range(99) < 55 && lane_len[k] >= 1 && lane_len[k] <= MAX_LEN) begin
        for (j = 0; j < lane_len[k]; j++) begin
          b = lane_pat[k][8*j +: 8];
          if ($urandom_range(99) < 8) b = alphabet[$urandom_range(3)];
          send_item(vary_case(b), $urandom_range(99) < 3);
          sent++;
        end
      end else if ($urandom_range(99) < 70) begin
        send_item(vary_case(alphabet[$urandom_range(3)]), $urandom_range(99) < 3);
        sent++;
      end else begin
        send_item(8'($urandom_range(255)), $urandom_range(99) < 3);
        sent++;
      end
    end
  endtask

  // receiver: checks results and drives out_ready
  initial begin
    int stall_left;
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        scoreboard.check_result(match_mask, byte_position, total_matches);
      if (stall_request > 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int phase;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    data_byte       = '0;
    first_of_buffer = 1'b0;
    send_idle_pct   = 6;
    recv_idle_pct   = 6;
    stall_request   = 0;
    scoreboard      = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset registers: every lane disabled
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(CHAR_UPPER_A, 1'b0);
    drain();

    write_reg(CFG_PATTERN_ZERO, 64'h5A5A_5A5A_5A63_6261);
    write_reg(CFG_PATTERN_ONE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PATTERN_TWO, 64'h0123_4567_89AB_CDFF);
    write_reg(CFG_PATTERN_THREE, 64'h0000_0000_0000_5B40);
    write_reg(CFG_LENGTHS, 64'hFFFF_0000_0000_2183);
    write_reg(CFG_CASE, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(CFG_UNUSED_LO, '1);
    write_reg(CFG_UNUSED_HI, '1);

    // folded match
    send_item(CHAR_UPPER_A, 1'b1);
    send_item(CHAR_UPPER_A + 8'd1, 1'b0);
    send_item(CHAR_UPPER_A + 8'd2, 1'b0);
    // overlapping prefix missed
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b0);
    // bytes next to the folded range
    send_item(8'h60, 1'b0);
    send_item(8'h7B, 1'b1);
    send_item(8'h40, 1'b0);
    send_item(8'h5B, 1'b0);
    // two lanes complete on the same byte
    repeat (8) send_item(8'hFF, 1'b0);
    // progress left past a shortened length
    send_item(8'h61, 1'b1);
    send_item(8'h62, 1'b0);
    drain();
    write_reg(CFG_LENGTHS, 64'h2181);
    send_item(8'h61, 1'b0);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      random_setup(phase);
      send_idle_pct = (phase == 5) ? 0 : 6;
      recv_idle_pct = (phase == 5) ? 0 : 6;
      if (phase == 3) stall_request = 60;
      if (phase == 4) begin
        random_text(PHASE_ITEMS / 2);
        drain();
        random_text(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        random_text(PHASE_ITEMS);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (scoreboard.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
